### hdl/ucpd_pkg.sv
package ucpd_pkg;

  localparam int unsigned CNT_W = 4;

  localparam logic [15:0] GAP_LIMIT_RESET = 16'd30;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  localparam logic       IN_CMD_BYTE     = 1'b0;
  localparam logic       IN_CMD_OVERFLOW = 1'b1;

  localparam logic [7:0] CMD_GET_REG = 8'h01;
  localparam logic [7:0] CMD_SET_REG = 8'h02;

  typedef enum logic [1:0] {
    ST_GET_REG  = 2'd0,
    ST_SET_REG  = 2'd1,
    ST_CRC_ERR  = 2'd2,
    ST_UNKNOWN  = 2'd3
  } ucpd_status_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic [15:0] gap_ticks;
  } ucpd_in_t;

  typedef struct packed {
    ucpd_status_t status;
    logic [7:0]   command;
    logic [6:0]   spi_address;
  } ucpd_out_t;

  // One classified word in the queue: restart clears framing first, and
  // has_byte says whether a data byte follows the restart.
  typedef struct packed {
    logic       restart;
    logic       has_byte;
    logic [7:0] data;
  } ucpd_entry_t;

endpackage

### hdl/ucpd_front.sv
module ucpd_front import ucpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ucpd_in_t    in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        push_valid,
  input  logic        push_ready,
  output ucpd_entry_t push_entry
);

  logic [15:0] gap_limit_r;
  logic [15:0] gap_limit_nxt;

  always_comb begin
    gap_limit_nxt = gap_limit_r;
    if (cfg_we) begin
      gap_limit_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RESET;
    end else begin
      gap_limit_r <= gap_limit_nxt;
    end
  end

  // A timer overflow restarts framing with no byte; a long idle gap
  // restarts framing and the byte opens the new packet.
  always_comb begin
    push_entry.data     = in_data.rx_byte;
    push_entry.has_byte = (in_data.cmd == IN_CMD_BYTE);
    push_entry.restart  = (in_data.cmd == IN_CMD_OVERFLOW) ||
                          (in_data.gap_ticks > gap_limit_r);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

### hdl/ucpd_queue.sv
module ucpd_queue import ucpd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  ucpd_entry_t push_entry,
  output logic        pop_valid,
  input  logic        pop_ready,
  output ucpd_entry_t pop_entry
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ucpd_entry_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

### hdl/ucpd_back.sv
module ucpd_back import ucpd_pkg::*; #(
  parameter int unsigned MAX_PACKET = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  ucpd_entry_t pop_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output ucpd_out_t   out_data
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET);

  function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       packet_length_r, packet_length_nxt;
  logic [15:0]      running_crc_r, running_crc_nxt;
  logic [7:0]       command_byte_r, command_byte_nxt;
  logic [7:0]       address_byte_r, address_byte_nxt;
  logic             out_valid_r, out_valid_nxt;
  ucpd_out_t        out_data_r, out_data_nxt;

  logic             fire;
  logic             complete;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_inc;
  logic [15:0]      crc_cur;
  ucpd_status_t     status;

  assign pop_ready = !out_valid_r || out_ready;
  assign fire      = pop_valid && pop_ready;

  always_comb begin
    byte_count_nxt    = byte_count_r;
    packet_length_nxt = packet_length_r;
    running_crc_nxt   = running_crc_r;
    command_byte_nxt  = command_byte_r;
    address_byte_nxt  = address_byte_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_data_nxt      = out_data_r;

    pos      = pop_entry.restart ? '0 : byte_count_r;
    pos_inc  = pos + 1'b1;
    crc_cur  = running_crc_r;
    complete = 1'b0;
    status   = ST_UNKNOWN;

    if (pos == '0) begin
      packet_length_nxt = pop_entry.data;
      crc_cur           = CRC_INIT;
      command_byte_nxt  = '0;
      address_byte_nxt  = '0;
    end
    if (pos == CNT_W'(1)) begin
      command_byte_nxt = pop_entry.data;
    end
    if (pos == CNT_W'(2)) begin
      address_byte_nxt = pop_entry.data;
    end

    complete = (packet_length_nxt == {{(8 - CNT_W){1'b0}}, pos_inc});

    if (crc_cur[7:0] != pop_entry.data) begin
      status = ST_CRC_ERR;
    end else if (packet_length_nxt < 8'd3) begin
      status = ST_UNKNOWN;
    end else if (command_byte_nxt == CMD_GET_REG) begin
      status = ST_GET_REG;
    end else if (command_byte_nxt == CMD_SET_REG) begin
      status = ST_SET_REG;
    end else begin
      status = ST_UNKNOWN;
    end

    if (fire) begin
      if (!pop_entry.has_byte) begin
        // Timer overflow: only the framing position is cleared.
        byte_count_nxt    = '0;
        packet_length_nxt = packet_length_r;
        command_byte_nxt  = command_byte_r;
        address_byte_nxt  = address_byte_r;
        out_valid_nxt     = 1'b0;
      end else if (complete) begin
        byte_count_nxt           = '0;
        running_crc_nxt          = crc_cur;
        out_valid_nxt            = 1'b1;
        out_data_nxt.status      = status;
        out_data_nxt.command     = command_byte_nxt;
        out_data_nxt.spi_address = address_byte_nxt[6:0];
      end else begin
        running_crc_nxt = crc_update(crc_cur, pop_entry.data);
        byte_count_nxt  = (pos_inc >= CNT_MAX) ? '0 : pos_inc;
        out_valid_nxt   = 1'b0;
      end
    end else begin
      packet_length_nxt = packet_length_r;
      command_byte_nxt  = command_byte_r;
      address_byte_nxt  = address_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      packet_length_r <= '0;
      running_crc_r   <= CRC_INIT;
      command_byte_r  <= '0;
      address_byte_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      byte_count_r    <= byte_count_nxt;
      packet_length_r <= packet_length_nxt;
      running_crc_r   <= running_crc_nxt;
      command_byte_r  <= command_byte_nxt;
      address_byte_r  <= address_byte_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r < CNT_MAX)
    else $error("byte position reached maximum packet length");

  a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !pop_entry.has_byte) |=> (byte_count_r == '0))
    else $error("overflow did not restart framing");

  a_get_command: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_GET_REG)) |->
      (out_data_r.command == CMD_GET_REG))
    else $error("get status with another command byte");

  a_result_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pop_entry.has_byte && complete) |=> (byte_count_r == '0))
    else $error("completed packet left framing open");
`endif

endmodule

### hdl/uart_command_packet_deframer_top.sv
// UART command packet deframer.
// Input channel (in_valid/in_ready/in_data): one word per received UART
// byte, tagged with the idle ticks since the previous byte, or a timer
// overflow word that restarts framing. Output channel (out_valid/out_ready/
// out_data): one word per completed packet with status, command byte and
// register address. cfg_we/cfg_wdata write the idle gap limit.
// A word accepted at one edge is classified and enters a short queue; the
// framer pops it once its output register is empty or being read, and the
// result of a completed packet is registered there. The framer holds the
// whole packet state and the byte-wide CRC update and, unless the output
// stalls, takes one word per cycle, so each side sustains one per cycle.
// When the receiver stalls, the result waits in the output register and
// the framer stops taking words; the queue absorbs up to QUEUE_DEPTH more
// words before in_ready falls.
// Reset clears framing, sets the CRC to its initial value, empties the
// queue and sets the gap limit to 30 ticks. No clearing pass is needed.
module uart_command_packet_deframer_top import ucpd_pkg::*; #(
  parameter int unsigned MAX_PACKET  = 10,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ucpd_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ucpd_out_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        push_valid, push_ready;
  ucpd_entry_t push_entry;
  logic        pop_valid, pop_ready;
  ucpd_entry_t pop_entry;

  ucpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ucpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  ucpd_back #(
    .MAX_PACKET (MAX_PACKET)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/uart_command_packet_deframer_top_tb.sv
module uart_command_packet_deframer_top_tb import ucpd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PACKET = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ucpd_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ucpd_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Framer state mirrored on every accepted word.
  logic [15:0] cur_gap_limit = GAP_LIMIT_RESET;
  logic [3:0]  fr_count = '0;
  logic [7:0]  fr_length = '0;
  logic [15:0] fr_crc = CRC_INIT;
  logic [7:0]  fr_command = '0;
  logic [7:0]  fr_address = '0;

  ucpd_out_t   pending_results[$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left = 0;

  uart_command_packet_deframer_top #(
    .MAX_PACKET(MAX_PACKET)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("uart_command_packet_deframer_top_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void advance_framer(input ucpd_in_t w);
    logic [3:0] pos;
    ucpd_out_t  r;
    if (w.cmd == IN_CMD_OVERFLOW) begin
      fr_count = '0;
      return;
    end
    if (w.gap_ticks > cur_gap_limit) fr_count = '0;
    pos = fr_count;
    if (pos == 4'd0) begin
      fr_length  = w.rx_byte;
      fr_crc     = CRC_INIT;
      fr_command = '0;
      fr_address = '0;
    end
    if (pos == 4'd1) fr_command = w.rx_byte;
    if (pos == 4'd2) fr_address = w.rx_byte;
    fr_count = pos + 4'd1;
    if (fr_length == {4'd0, fr_count}) begin
      fr_count = '0;
      if (fr_crc[7:0] != w.rx_byte) r.status = ST_CRC_ERR;
      else if (fr_length < 8'd3) r.status = ST_UNKNOWN;
      else if (fr_command == CMD_GET_REG) r.status = ST_GET_REG;
      else if (fr_command == CMD_SET_REG) r.status = ST_SET_REG;
      else r.status = ST_UNKNOWN;
      r.command     = fr_command;
      r.spi_address = fr_address[6:0];
      pending_results.push_back(r);
    end else begin
      fr_crc = crc16_ccitt_byte(fr_crc, w.rx_byte);
      if (fr_count >= MAX_PACKET) fr_count = '0;
    end
  endfunction

  // Valid is only lowered when an idle gap follows, so a word offered
  // back to back never sees valid dropped and raised in one step.
  task automatic send_word(input ucpd_in_t w);
    int idle;
    idle = 0;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) idle++;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    advance_framer(w);
    words_sent++;
  endtask

  task automatic sender_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic [15:0] g);
    ucpd_in_t w;
    w.cmd       = IN_CMD_BYTE;
    w.rx_byte   = b;
    w.gap_ticks = g;
    send_word(w);
  endtask

  task automatic send_overflow();
    ucpd_in_t w;
    w.cmd       = IN_CMD_OVERFLOW;
    w.rx_byte   = 8'($urandom);
    w.gap_ticks = 16'($urandom);
    send_word(w);
  endtask

  task automatic wait_for_results();
    sender_quiet();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Words that give no result may still sit in the input queue.
  task automatic drain_block();
    wait_for_results();
    repeat (10) @(posedge clk);
  endtask

  task automatic write_gap_limit(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_gap_limit = v;
    @(posedge clk);
  endtask

  // Gap for a first byte: force a restart unless framing is already idle.
  task automatic packet_start_gap(output logic [15:0] g);
    if (cur_gap_limit == 16'hFFFF) begin
      if (fr_count != 4'd0) send_overflow();
      g = 16'($urandom);
    end else if (fr_count == 4'd0 && $urandom_range(3) == 0) begin
      g = 16'($urandom_range(int'(cur_gap_limit)));
    end else begin
      g = 16'($urandom_range(65535, int'(cur_gap_limit) + 1));
    end
  endtask

  task automatic send_packet(input int len, input logic [7:0] cmd_b,
                             input logic [7:0] addr_b, input bit bad_crc,
                             input int cut, input bit edge_gaps);
    int          n;
    int          i;
    logic [15:0] crc;
    logic [7:0]  b;
    logic [15:0] g;
    n = (len == 0 || len > MAX_PACKET) ? MAX_PACKET : len;
    if (cut > 0 && cut < n) n = cut;
    crc = CRC_INIT;
    for (i = 0; i < n; i++) begin
      if (i == 0) b = 8'(len);
      else if (i == len - 1) b = crc[7:0] ^ (bad_crc ? 8'($urandom_range(255, 1)) : 8'h00);
      else if (i == 1) b = cmd_b;
      else if (i == 2) b = addr_b;
      else b = 8'($urandom);
      if (i == 0) begin
        if (edge_gaps) g = 16'hFFFF;
        else packet_start_gap(g);
      end else if (edge_gaps) begin
        g = (i % 2) ? 16'h0000 : cur_gap_limit;
      end else if ($urandom_range(3) == 0) begin
        g = cur_gap_limit;
      end else begin
        g = 16'($urandom_range(int'(cur_gap_limit)));
      end
      send_byte(b, g);
      crc = crc16_ccitt_byte(crc, b);
    end
  endtask

  task automatic send_random_packet();
    int         r;
    int         len;
    int         cut;
    logic [7:0] cmd_b;
    r = $urandom_range(99);
    if (r < 75) len = $urandom_range(MAX_PACKET, 3);
    else if (r < 85) len = $urandom_range(2, 1);
    else if (r < 92) len = 0;
    else len = $urandom_range(255, MAX_PACKET + 1);
    r = $urandom_range(9);
    if (r < 4) cmd_b = CMD_GET_REG;
    else if (r < 7) cmd_b = CMD_SET_REG;
    else cmd_b = 8'($urandom);
    cut = ($urandom_range(99) < 10) ? $urandom_range(MAX_PACKET - 1, 1) : 0;
    send_packet(len, cmd_b, 8'($urandom), $urandom_range(99) < 15, cut, 1'b0);
    if (cut > 0 && $urandom_range(1) == 1) send_overflow();
  endtask

  task automatic random_traffic(input int n);
    int       target;
    ucpd_in_t w;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(99) < 12) begin
        w.cmd       = 1'($urandom_range(1));
        w.rx_byte   = 8'($urandom);
        w.gap_ticks = 16'($urandom);
        send_word(w);
      end else begin
        send_random_packet();
      end
    end
  endtask

  task automatic test_directed();
    send_overflow();
    send_packet(3, CMD_GET_REG, 8'h00, 1'b0, 0, 1'b1);
    send_packet(4, CMD_SET_REG, 8'hFF, 1'b0, 0, 1'b1);
    send_packet(4, 8'h00, 8'h80, 1'b0, 0, 1'b1);
    // A one-byte packet carries its length as its CRC byte.
    send_packet(1, 8'h00, 8'h00, 1'b0, 0, 1'b1);
    send_packet(2, 8'h00, 8'h00, 1'b0, 0, 1'b1);
    send_packet(3, CMD_GET_REG, 8'h00, 1'b1, 0, 1'b1);
    send_packet(5, CMD_GET_REG, 8'h7F, 1'b0, 2, 1'b1);
    send_overflow();
    send_packet(3, CMD_SET_REG, 8'h00, 1'b0, 0, 1'b0);
    drain_block();
  endtask

  task automatic test_gap_limit_phases();
    drain_block();
    write_gap_limit(16'h0000);
    random_traffic(250);
    drain_block();
    sender_idle_pct = 71;
    write_gap_limit(16'hFFFF);
    random_traffic(250);
    drain_block();
    sender_idle_pct = 0;
    recv_stall_pct  = 71;
    write_gap_limit(16'($urandom_range(5000, 1)));
    random_traffic(250);
    drain_block();
    sender_idle_pct = 32;
    recv_stall_pct  = 32;
    write_gap_limit(GAP_LIMIT_RESET);
    random_traffic(250);
    drain_block();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  // The receiver holds off while short packets keep coming, so results
  // pile up and the input side must stall.
  task automatic test_output_backpressure();
    int k;
    hold_off_left = 300;
    for (k = 0; k < 20; k++) begin
      send_packet(3, CMD_GET_REG, 8'($urandom), 1'b0, 0, 1'b0);
    end
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    int k;
    recv_stall_pct = 32;
    for (k = 0; k < 6; k++) begin
      send_random_packet();
      send_random_packet();
      wait_for_results();
    end
    recv_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    ucpd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d cmd %02h addr %02h",
                                  out_data.status, out_data.command, out_data.spi_address));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
        end
        if (out_data.command != want.command) begin
          report_mismatch($sformatf("command %02h, expected %02h",
                                    out_data.command, want.command));
        end
        if (out_data.spi_address != want.spi_address) begin
          report_mismatch($sformatf("spi_address %02h, expected %02h",
                                    out_data.spi_address, want.spi_address));
        end
      end
    end
  end

  // Receiver: a hold-off counts down one cycle at a time, otherwise it
  // stalls at random.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int wait_cycles;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_gap_limit_phases();
    test_output_backpressure();
    test_sender_pause();
    recv_stall_pct  = 0;
    sender_idle_pct = 0;
    sender_quiet();
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("uart_command_packet_deframer_top_tb: PASS");
    end else begin
      $display("uart_command_packet_deframer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
